/* src/gcr_pkg.sv */
// Shared constants, types and state codes of the graph color refinement block.
`default_nettype none
package gcr_pkg;
	localparam int MAX_NODES   = 64;
	localparam int MAX_EDGES   = 512;
	localparam int MAX_WEIGHTS = 4;
	localparam int NODE_W      = $clog2(MAX_NODES);
	localparam int NUM_W       = NODE_W + 1;
	localparam int EDGE_AW     = $clog2(MAX_EDGES);
	localparam int ECNT_W      = EDGE_AW + 1;
	localparam int WGT_W       = $clog2(MAX_WEIGHTS);
	localparam int WK_W        = 3;
	localparam int VEC_AW      = NODE_W + WGT_W;
	localparam int CNT_AW      = NODE_W + VEC_AW;
	localparam int CNT_W       = 10;
	localparam int TAG_W       = 8;
	localparam int CNT_DW      = TAG_W + CNT_W;
	localparam int EDGE_DW     = 2 * NODE_W + WGT_W;
	localparam int IN_DATA_W   = 32;
	localparam int IN_USER_W   = 2;
	localparam int OUT_DATA_W  = 16;
	localparam int APB_AW      = 4;
	localparam int APB_DW      = 32;
	localparam logic [CNT_W-1:0] COUNT_MAX = '1;
	localparam logic [TAG_W-1:0] TAG_LAST  = '1;

	typedef enum logic [1:0] {
		OP_LOAD_NODE   = 2'd0,
		OP_LOAD_EDGE   = 2'd1,
		OP_START       = 2'd2,
		OP_CLEAR_EDGES = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_DIRECTED     = 2'd0,
		REG_USE_WEIGHTS  = 2'd1,
		REG_WEIGHT_KINDS = 2'd2,
		REG_NODE_TOTAL   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic            directed;
		logic            use_weights;
		logic [WK_W-1:0] weight_kinds;
		logic [6:0]      node_total;
	} cfg_t;

	typedef enum logic [4:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_INIT_RD,
		ST_INIT_ACC,
		ST_ROUND,
		ST_EDGE_RD,
		ST_EDGE_CS,
		ST_EDGE_CD,
		ST_EDGE_CHK,
		ST_BUMP_D,
		ST_BUMP_S_RD,
		ST_BUMP_S,
		ST_CLS_I,
		ST_CLS_J,
		ST_CLS_REP,
		ST_CMP_A,
		ST_CMP_B,
		ST_CMP_EQ,
		ST_CLS_WR,
		ST_ROUND_END,
		ST_OUT_RD,
		ST_OUT_LD
	} state_t;
endpackage
`default_nettype wire

/* src/gcr_ram.sv */
// Generic synchronous RAM with one write port and one registered read port.
`default_nettype none
module gcr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

/* src/gcr_regs.sv */
// APB configuration registers of the graph color refinement block.
`default_nettype none
module gcr_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [gcr_pkg::APB_AW-1:0]  paddr,
	input  wire logic [gcr_pkg::APB_DW-1:0]  pwdata,
	output logic      [gcr_pkg::APB_DW-1:0]  prdata,
	output logic                             pready,
	output gcr_pkg::cfg_t                    cfg
);
	import gcr_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.directed     <= 1'b0;
			cfg_q.use_weights  <= 1'b0;
			cfg_q.weight_kinds <= WK_W'(1);
			cfg_q.node_total   <= 7'd64;
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_DIRECTED:     cfg_q.directed     <= pwdata[0];
				REG_USE_WEIGHTS:  cfg_q.use_weights  <= pwdata[0];
				REG_WEIGHT_KINDS: cfg_q.weight_kinds <= pwdata[WK_W-1:0];
				REG_NODE_TOTAL:   cfg_q.node_total   <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_DIRECTED:     prdata[0]        = cfg_q.directed;
			REG_USE_WEIGHTS:  prdata[0]        = cfg_q.use_weights;
			REG_WEIGHT_KINDS: prdata[WK_W-1:0] = cfg_q.weight_kinds;
			REG_NODE_TOTAL:   prdata[6:0]      = cfg_q.node_total;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

/* src/graph_color_refinement.sv */
// Top level of the graph color refinement block: sequencer around four RAMs.
//
//  channel   | role   | handshake             | payload
//  s_axis    | in     | tvalid/tready         | tuser op, tdata node and edge fields
//  m_axis    | out    | tvalid/tready/tlast   | tdata node and color, tlast last node
//  apb       | config | psel/penable, pready  | four registers at 4*i
//
// Node loads, edge loads and edge clears are taken in the idle state.
// A start scans the nodes, then per round updates the count RAM for each edge in range
// (read-modify-write of the count RAM) and compares the vectors position by position,
// then emits the nodes one by one; the count RAM has a single read port.
// After reset, and after every 255 rounds, a pass over the whole count RAM clears its tags;
// no request is taken meanwhile. A stalled last result is held while loads are accepted.
`default_nettype none
module graph_color_refinement (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	// [5:0] node_index, [12:6] initial_color, [13] is_fixed, [20:14] edge_from,
	// [27:21] edge_to, [30:28] edge_weight, [31] zero
	input  wire logic [gcr_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// [1:0] op
	input  wire logic [gcr_pkg::IN_USER_W-1:0]   s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// [6:0] out_node, [13:7] out_color, [15:14] zero
	output logic      [gcr_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	output logic                                 m_axis_tlast,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [gcr_pkg::APB_AW-1:0]      paddr,
	input  wire logic [gcr_pkg::APB_DW-1:0]      pwdata,
	output logic      [gcr_pkg::APB_DW-1:0]      prdata,
	output logic                                 pready
);
	import gcr_pkg::*;

	cfg_t cfg;

	gcr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	state_t state_q, state_d, sweep_ret_q;

	logic [TAG_W-1:0]  epoch_q;
	logic [CNT_AW-1:0] sweep_addr_q;
	logic [NUM_W-1:0]  idx_q, ncol_q, nfix_q, ntypes_q, rank_q, j_q;
	logic [NODE_W-1:0] round_q;
	logic [ECNT_W-1:0] e_q, edge_count_q;
	logic [VEC_AW-1:0] p_q, pos_s_q;
	logic [NODE_W-1:0] rep_q, src_q, dst_q, csrc_q;
	logic [WGT_W-1:0]  wgt_q;
	logic [CNT_AW-1:0] cnt_addr_q;
	logic [CNT_W-1:0]  cnt_a_q;
	logic [MAX_NODES-1:0] fixed_q;
	logic              out_valid_q, out_last_q;
	logic [NUM_W-1:0]  out_node_q, out_color_q;

	logic               color_we, edge_we, rep_we, cnt_we;
	logic [NODE_W-1:0]  color_waddr, color_wdata, color_raddr, color_rdata;
	logic [EDGE_AW-1:0] edge_waddr, edge_raddr;
	logic [EDGE_DW-1:0] edge_wdata, edge_rdata;
	logic [NODE_W-1:0]  rep_waddr, rep_wdata, rep_raddr, rep_rdata;
	logic [CNT_AW-1:0]  cnt_waddr, cnt_raddr;
	logic [CNT_DW-1:0]  cnt_wdata, cnt_rdata;

	gcr_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_color_ram (
		.clk(clk), .we(color_we), .waddr(color_waddr), .wdata(color_wdata),
		.raddr(color_raddr), .rdata(color_rdata)
	);
	gcr_ram #(.WIDTH(EDGE_DW), .DEPTH(MAX_EDGES)) u_edge_ram (
		.clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
		.raddr(edge_raddr), .rdata(edge_rdata)
	);
	gcr_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_rep_ram (
		.clk(clk), .we(rep_we), .waddr(rep_waddr), .wdata(rep_wdata),
		.raddr(rep_raddr), .rdata(rep_rdata)
	);
	gcr_ram #(.WIDTH(CNT_DW), .DEPTH(2 ** CNT_AW)) u_cnt_ram (
		.clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
		.raddr(cnt_raddr), .rdata(cnt_rdata)
	);

	function automatic logic [VEC_AW-1:0] vec_pos(input logic [NODE_W-1:0] c,
			input logic [WK_W-1:0] wk, input logic [WGT_W-1:0] wix);
		logic [NODE_W+WK_W-1:0] prod;
		logic [NODE_W+WK_W-1:0] sum;
		prod = {{WK_W{1'b0}}, c} * {{NODE_W{1'b0}}, wk};
		sum  = prod + {{(NODE_W+WK_W-WGT_W){1'b0}}, wix};
		return sum[VEC_AW-1:0];
	endfunction

	// A count entry whose tag is not the current round's epoch reads as zero.
	function automatic logic [CNT_W-1:0] cnt_value(input logic [CNT_DW-1:0] d,
			input logic [TAG_W-1:0] ep);
		return (d[CNT_DW-1:CNT_W] == ep) ? d[CNT_W-1:0] : '0;
	endfunction

	op_t               in_op;
	logic [NODE_W-1:0] in_node;
	logic [NUM_W-1:0]  in_color, in_from, in_to;
	logic              in_fixed, in_accept, edge_ok;
	logic [WK_W-1:0]   in_wgt;
	logic [NODE_W-1:0] in_color_ld;
	logic [WGT_W-1:0]  in_wgt_ld;

	assign in_op     = op_t'(s_axis_tuser);
	assign in_node   = s_axis_tdata[5:0];
	assign in_color  = s_axis_tdata[12:6];
	assign in_fixed  = s_axis_tdata[13];
	assign in_from   = s_axis_tdata[20:14];
	assign in_to     = s_axis_tdata[27:21];
	assign in_wgt    = s_axis_tdata[30:28];
	assign in_accept = s_axis_tvalid && s_axis_tready;

	assign in_color_ld = (in_color == '0) ? '0 :
		(in_color > NUM_W'(MAX_NODES)) ? NODE_W'(MAX_NODES - 1) : NODE_W'(in_color - 1'b1);
	assign in_wgt_ld = (in_wgt == '0) ? '0 :
		(in_wgt > WK_W'(MAX_WEIGHTS)) ? WGT_W'(MAX_WEIGHTS - 1) : WGT_W'(in_wgt - 1'b1);
	assign edge_ok = (in_from != '0) && (in_from <= NUM_W'(MAX_NODES)) && (in_to != '0) &&
		(in_to <= NUM_W'(MAX_NODES)) && (edge_count_q != ECNT_W'(MAX_EDGES));

	logic [NUM_W-1:0]  n_nodes;
	logic [WK_W-1:0]   w_kinds;
	logic [WGT_W-1:0]  wi;
	logic [VEC_AW:0]   len_full;
	logic [VEC_AW-1:0] len_last;
	logic [NUM_W:0]    noc_sum, cls_sum;
	logic [NUM_W-1:0]  noc;
	logic [NODE_W-1:0] cls_color, rank_color;
	logic              pin;
	logic [CNT_W-1:0]  cnt_cur, cnt_next;
	logic [NUM_W:0]    ncol_cand;

	assign n_nodes = (cfg.node_total == '0) ? NUM_W'(1) :
		(cfg.node_total > NUM_W'(MAX_NODES)) ? NUM_W'(MAX_NODES) : cfg.node_total;
	assign w_kinds = !cfg.use_weights ? WK_W'(1) :
		(cfg.weight_kinds == '0) ? WK_W'(1) :
		(cfg.weight_kinds > WK_W'(MAX_WEIGHTS)) ? WK_W'(MAX_WEIGHTS) : cfg.weight_kinds;
	assign wi = !cfg.use_weights ? '0 :
		({1'b0, wgt_q} > WK_W'(w_kinds - 1'b1)) ? WGT_W'(w_kinds - 1'b1) : wgt_q;
	assign len_full = (VEC_AW+1)'({{WK_W{1'b0}}, ncol_q} * {{NUM_W{1'b0}}, w_kinds});
	assign len_last = VEC_AW'(len_full - 1'b1);
	assign noc_sum  = {1'b0, ntypes_q} + {1'b0, nfix_q};
	assign noc      = (noc_sum > (NUM_W+1)'(MAX_NODES)) ? NUM_W'(MAX_NODES) : NUM_W'(noc_sum);
	assign cls_sum  = {1'b0, j_q} + {1'b0, nfix_q};
	assign cls_color = (cls_sum > (NUM_W+1)'(MAX_NODES - 1)) ? NODE_W'(MAX_NODES - 1) :
		NODE_W'(cls_sum);
	assign rank_color = (rank_q > NUM_W'(MAX_NODES - 1)) ? NODE_W'(MAX_NODES - 1) :
		NODE_W'(rank_q);
	assign pin      = cfg.directed && fixed_q[idx_q[NODE_W-1:0]];
	assign cnt_cur  = cnt_value(cnt_rdata, epoch_q);
	assign cnt_next = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + 1'b1;
	assign ncol_cand = {2'b00, color_rdata} + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		color_we      = 1'b0;
		color_waddr   = idx_q[NODE_W-1:0];
		color_wdata   = pin ? rank_color : cls_color;
		color_raddr   = idx_q[NODE_W-1:0];
		edge_we       = 1'b0;
		edge_waddr    = edge_count_q[EDGE_AW-1:0];
		edge_wdata    = {in_wgt_ld, NODE_W'(in_to - 1'b1), NODE_W'(in_from - 1'b1)};
		edge_raddr    = e_q[EDGE_AW-1:0];
		rep_we        = 1'b0;
		rep_waddr     = ntypes_q[NODE_W-1:0];
		rep_wdata     = idx_q[NODE_W-1:0];
		rep_raddr     = j_q[NODE_W-1:0];
		cnt_we        = 1'b0;
		cnt_waddr     = cnt_addr_q;
		cnt_wdata     = {epoch_q, cnt_next};
		cnt_raddr     = {rep_q, p_q};
		case (state_q)
			ST_SWEEP: begin
				cnt_we    = 1'b1;
				cnt_waddr = sweep_addr_q;
				cnt_wdata = '0;
				if (sweep_addr_q == '1) state_d = sweep_ret_q;
			end
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					case (in_op)
						OP_LOAD_NODE: begin
							color_we    = 1'b1;
							color_waddr = in_node;
							color_wdata = in_color_ld;
						end
						OP_LOAD_EDGE: edge_we = edge_ok;
						OP_START:     state_d = ST_INIT_RD;
						default: ;
					endcase
				end
			end
			ST_INIT_RD:  state_d = ST_INIT_ACC;
			ST_INIT_ACC: state_d = (idx_q == n_nodes - 1'b1) ? ST_ROUND : ST_INIT_RD;
			ST_ROUND:    state_d = (epoch_q == TAG_LAST) ? ST_SWEEP : ST_EDGE_RD;
			ST_EDGE_RD:  state_d = (e_q == edge_count_q) ? ST_CLS_I : ST_EDGE_CS;
			ST_EDGE_CS: begin
				color_raddr = edge_rdata[NODE_W-1:0];
				state_d     = ST_EDGE_CD;
			end
			ST_EDGE_CD: begin
				color_raddr = dst_q;
				state_d     = ST_EDGE_CHK;
			end
			ST_EDGE_CHK: begin
				cnt_raddr = {dst_q, vec_pos(csrc_q, w_kinds, wi)};
				if (({1'b0, src_q} >= n_nodes) || ({1'b0, dst_q} >= n_nodes)) begin
					state_d = ST_EDGE_RD;
				end else begin
					state_d = ST_BUMP_D;
				end
			end
			ST_BUMP_D: begin
				cnt_we  = 1'b1;
				state_d = cfg.directed ? ST_EDGE_RD : ST_BUMP_S_RD;
			end
			ST_BUMP_S_RD: begin
				cnt_raddr = {src_q, pos_s_q};
				state_d   = ST_BUMP_S;
			end
			ST_BUMP_S: begin
				cnt_we  = 1'b1;
				state_d = ST_EDGE_RD;
			end
			ST_CLS_I: state_d = (idx_q == n_nodes) ? ST_ROUND_END : ST_CLS_J;
			ST_CLS_J: begin
				if (j_q == ntypes_q) begin
					rep_we  = 1'b1;
					state_d = ST_CLS_WR;
				end else begin
					state_d = ST_CLS_REP;
				end
			end
			ST_CLS_REP: state_d = ST_CMP_A;
			ST_CMP_A: begin
				cnt_raddr = {rep_q, p_q};
				state_d   = ST_CMP_B;
			end
			ST_CMP_B: begin
				cnt_raddr = {idx_q[NODE_W-1:0], p_q};
				state_d   = ST_CMP_EQ;
			end
			ST_CMP_EQ: begin
				if (cnt_cur != cnt_a_q) begin
					state_d = ST_CLS_J;
				end else if (p_q == len_last) begin
					state_d = ST_CLS_WR;
				end else begin
					state_d = ST_CMP_A;
				end
			end
			ST_CLS_WR: begin
				color_we = 1'b1;
				state_d  = ST_CLS_I;
			end
			ST_ROUND_END: begin
				if ((noc == ncol_q) || (round_q == NODE_W'(MAX_NODES - 1))) begin
					state_d = ST_OUT_RD;
				end else begin
					state_d = ST_ROUND;
				end
			end
			ST_OUT_RD: if (!out_valid_q) state_d = ST_OUT_LD;
			ST_OUT_LD: state_d = (idx_q == n_nodes - 1'b1) ? ST_IDLE : ST_OUT_RD;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_ret_q  <= ST_IDLE;
			sweep_addr_q <= '0;
			epoch_q      <= '0;
			idx_q        <= '0;
			ncol_q       <= '0;
			nfix_q       <= '0;
			ntypes_q     <= '0;
			rank_q       <= '0;
			j_q          <= '0;
			round_q      <= '0;
			e_q          <= '0;
			edge_count_q <= '0;
			p_q          <= '0;
			fixed_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (state_q == ST_OUT_LD) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_SWEEP: begin
					sweep_addr_q <= sweep_addr_q + 1'b1;
					if (sweep_addr_q == '1) epoch_q <= '0;
				end
				ST_IDLE: begin
					if (in_accept) begin
						case (in_op)
							OP_LOAD_NODE:   fixed_q[in_node] <= in_fixed;
							OP_LOAD_EDGE:   if (edge_ok) edge_count_q <= edge_count_q + 1'b1;
							OP_CLEAR_EDGES: edge_count_q <= '0;
							OP_START: begin
								idx_q   <= '0;
								ncol_q  <= NUM_W'(1);
								nfix_q  <= '0;
								round_q <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_INIT_ACC: begin
					if (ncol_cand > {1'b0, ncol_q}) ncol_q <= NUM_W'(ncol_cand);
					if (fixed_q[idx_q[NODE_W-1:0]]) nfix_q <= nfix_q + 1'b1;
					idx_q <= idx_q + 1'b1;
				end
				ST_ROUND: begin
					if (epoch_q == TAG_LAST) begin
						sweep_ret_q  <= ST_ROUND;
						sweep_addr_q <= '0;
					end else begin
						epoch_q  <= epoch_q + 1'b1;
						e_q      <= '0;
						idx_q    <= '0;
						ntypes_q <= '0;
						rank_q   <= '0;
					end
				end
				ST_EDGE_CS: begin
					src_q <= edge_rdata[NODE_W-1:0];
					dst_q <= edge_rdata[2*NODE_W-1:NODE_W];
					wgt_q <= edge_rdata[EDGE_DW-1:2*NODE_W];
				end
				ST_EDGE_CD: csrc_q <= color_rdata;
				ST_EDGE_CHK: begin
					if (({1'b0, src_q} >= n_nodes) || ({1'b0, dst_q} >= n_nodes)) begin
						e_q <= e_q + 1'b1;
					end else begin
						cnt_addr_q <= {dst_q, vec_pos(csrc_q, w_kinds, wi)};
						pos_s_q    <= vec_pos(color_rdata, w_kinds, wi);
					end
				end
				ST_BUMP_D:    if (cfg.directed) e_q <= e_q + 1'b1;
				ST_BUMP_S_RD: cnt_addr_q <= {src_q, pos_s_q};
				ST_BUMP_S:    e_q <= e_q + 1'b1;
				ST_CLS_I:     j_q <= '0;
				ST_CLS_J:     if (j_q == ntypes_q) ntypes_q <= ntypes_q + 1'b1;
				ST_CLS_REP: begin
					rep_q <= rep_rdata;
					p_q   <= '0;
				end
				ST_CMP_B: cnt_a_q <= cnt_cur;
				ST_CMP_EQ: begin
					if (cnt_cur != cnt_a_q) begin
						j_q <= j_q + 1'b1;
					end else if (p_q != len_last) begin
						p_q <= p_q + 1'b1;
					end
				end
				ST_CLS_WR: begin
					idx_q <= idx_q + 1'b1;
					if (pin) rank_q <= rank_q + 1'b1;
				end
				ST_ROUND_END: begin
					if ((noc == ncol_q) || (round_q == NODE_W'(MAX_NODES - 1))) begin
						idx_q <= '0;
					end else begin
						ncol_q  <= noc;
						round_q <= round_q + 1'b1;
					end
				end
				ST_OUT_LD: begin
					out_node_q  <= idx_q + 1'b1;
					out_color_q <= {1'b0, color_rdata} + 1'b1;
					out_last_q  <= (idx_q == n_nodes - 1'b1);
					idx_q       <= idx_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_color_q, out_node_q};
	assign m_axis_tlast  = out_last_q;

`ifndef ASSERT_OFF
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BUMP_D || state_q == ST_BUMP_S || state_q == ST_CMP_EQ) |->
		epoch_q != '0)
		else $error("Count access while the epoch aliases cleared tags.");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !cnt_we)
		else $error("Count RAM written while idle.");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_we && state_q != ST_SWEEP) |-> cnt_wdata[CNT_W-1:0] != '0)
		else $error("Count update wrote a zero count.");
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> out_node_q == n_nodes)
		else $error("Last result does not belong to the last node.");
`endif
endmodule
`default_nettype wire

/* tb/graph_color_refinement_checker.sv */
// Checker for the graph color refinement block: predicts node colors and compares results.
`timescale 1ns / 1ps
module graph_color_refinement_checker
	import gcr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	input  wire logic                  s_axis_tready,
	// [5:0] node_index, [12:6] initial_color, [13] is_fixed, [20:14] edge_from,
	// [27:21] edge_to, [30:28] edge_weight, [31] zero
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	// [1:0] op
	input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
	input  wire logic                  m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// [6:0] out_node, [13:7] out_color, [15:14] zero
	input  wire logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  wire logic                  m_axis_tlast,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_AW-1:0]     paddr,
	input  wire logic [APB_DW-1:0]     pwdata,
	input  wire logic                  pready,
	output int                         fail_count,
	output int                         pending
);
	typedef struct {
		logic [6:0] node;
		logic [6:0] color;
		logic       last;
	} node_color_t;

	node_color_t color_q[$];

	logic       cfg_directed = 1'b0;
	logic       cfg_use_weights = 1'b0;
	logic [2:0] cfg_weight_kinds = 3'd1;
	logic [6:0] cfg_node_total = 7'd64;

	logic [5:0] node_col [MAX_NODES];
	logic       node_fix [MAX_NODES];
	logic [5:0] edge_src [MAX_EDGES];
	logic [5:0] edge_dst [MAX_EDGES];
	logic [1:0] edge_wgt [MAX_EDGES];
	int         edge_total = 0;
	logic [9:0] vec_cnt [MAX_NODES][256];

	initial begin
		fail_count = 0;
		for (int i = 0; i < MAX_NODES; i++) begin
			node_col[i] = '0;
			node_fix[i] = 1'b0;
		end
	end

	assign pending = color_q.size();

	task automatic bump_count(int node, int pos);
		if (vec_cnt[node][pos] < 10'd1023)
			vec_cnt[node][pos] = vec_cnt[node][pos] + 10'd1;
	endtask

	task automatic predict_refinement();
		int n, w, ncol, nfix, len, ntypes, noc, rnk, s, d, wi, c, j;
		bit same, found;
		int rep[MAX_NODES];
		int cls[MAX_NODES];
		node_color_t r;
		n = cfg_node_total;
		if (n < 1) n = 1;
		if (n > MAX_NODES) n = MAX_NODES;
		w = 1;
		if (cfg_use_weights) begin
			w = cfg_weight_kinds;
			if (w < 1) w = 1;
			if (w > MAX_WEIGHTS) w = MAX_WEIGHTS;
		end
		ncol = 1;
		nfix = 0;
		for (int i = 0; i < n; i++) begin
			if (int'(node_col[i]) + 1 > ncol) ncol = int'(node_col[i]) + 1;
			if (node_fix[i]) nfix++;
		end
		for (int rnd = 0; rnd < MAX_NODES; rnd++) begin
			len = ncol * w;
			ntypes = 0;
			rnk = 0;
			for (int i = 0; i < MAX_NODES; i++)
				for (int k = 0; k < 256; k++)
					vec_cnt[i][k] = '0;
			for (int e = 0; e < edge_total; e++) begin
				s = edge_src[e];
				d = edge_dst[e];
				if (s >= n || d >= n) continue;
				wi = 0;
				if (cfg_use_weights) begin
					wi = edge_wgt[e];
					if (wi > w - 1) wi = w - 1;
				end
				if (!cfg_directed) bump_count(s, int'(node_col[d]) * w + wi);
				bump_count(d, int'(node_col[s]) * w + wi);
			end
			for (int i = 0; i < n; i++) begin
				found = 1'b0;
				j = 0;
				while (!found && j < ntypes) begin
					same = 1'b1;
					for (int k = 0; k < len; k++)
						if (vec_cnt[rep[j]][k] != vec_cnt[i][k]) same = 1'b0;
					if (same) found = 1'b1;
					else j++;
				end
				if (!found) begin
					rep[ntypes] = i;
					ntypes++;
				end
				cls[i] = j;
			end
			for (int i = 0; i < n; i++) begin
				c = cls[i] + nfix;
				if (c > MAX_NODES - 1) c = MAX_NODES - 1;
				node_col[i] = c[5:0];
			end
			if (cfg_directed) begin
				for (int i = 0; i < n; i++)
					if (node_fix[i]) begin
						c = (rnk < MAX_NODES - 1) ? rnk : MAX_NODES - 1;
						node_col[i] = c[5:0];
						rnk++;
					end
			end
			noc = ntypes + nfix;
			if (noc > MAX_NODES) noc = MAX_NODES;
			if (noc == ncol) break;
			ncol = noc;
		end
		for (int i = 0; i < n; i++) begin
			r.node = 7'(i + 1);
			r.color = 7'(int'(node_col[i]) + 1);
			r.last = (i + 1 == n);
			color_q = {color_q, r};
		end
	endtask

	always @(posedge clk) begin
		logic [6:0] col, fr, to;
		logic [2:0] wt;
		node_color_t exp_res;
		if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_DIRECTED:     cfg_directed = pwdata[0];
					REG_USE_WEIGHTS:  cfg_use_weights = pwdata[0];
					REG_WEIGHT_KINDS: cfg_weight_kinds = pwdata[2:0];
					REG_NODE_TOTAL:   cfg_node_total = pwdata[6:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				case (op_t'(s_axis_tuser))
					OP_LOAD_NODE: begin
						col = s_axis_tdata[12:6];
						if (col < 7'd1) col = 7'd1;
						if (col > 7'(MAX_NODES)) col = 7'(MAX_NODES);
						node_col[s_axis_tdata[5:0]] = 6'(col - 7'd1);
						node_fix[s_axis_tdata[5:0]] = s_axis_tdata[13];
					end
					OP_LOAD_EDGE: begin
						fr = s_axis_tdata[20:14];
						to = s_axis_tdata[27:21];
						wt = s_axis_tdata[30:28];
						if (edge_total < MAX_EDGES && fr >= 1 && fr <= MAX_NODES
								&& to >= 1 && to <= MAX_NODES) begin
							if (wt < 3'd1) wt = 3'd1;
							if (wt > 3'(MAX_WEIGHTS)) wt = 3'(MAX_WEIGHTS);
							edge_src[edge_total] = 6'(fr - 7'd1);
							edge_dst[edge_total] = 6'(to - 7'd1);
							edge_wgt[edge_total] = 2'(wt - 3'd1);
							edge_total++;
						end
					end
					OP_CLEAR_EDGES: edge_total = 0;
					default: predict_refinement();
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (color_q.size() == 0) begin
					$error("unexpected result node=%0d color=%0d",
						m_axis_tdata[6:0], m_axis_tdata[13:7]);
					fail_count++;
				end else begin
					exp_res = color_q.pop_front();
					if (m_axis_tdata[6:0] !== exp_res.node) begin
						$error("out_node expected %0d actual %0d", exp_res.node,
							m_axis_tdata[6:0]);
						fail_count++;
					end
					if (m_axis_tdata[13:7] !== exp_res.color) begin
						$error("out_color expected %0d actual %0d", exp_res.color,
							m_axis_tdata[13:7]);
						fail_count++;
					end
					if (m_axis_tlast !== exp_res.last) begin
						$error("last_node expected %0d actual %0d", exp_res.last,
							m_axis_tlast);
						fail_count++;
					end
				end
			end
		end
	end
endmodule

/* tb/graph_color_refinement_test.sv */
// Testbench top for the graph color refinement block: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module graph_color_refinement_test;
	import gcr_pkg::*;

	localparam longint CYCLE_LIMIT = 40_000_000;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic [IN_USER_W-1:0]  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_AW-1:0]     paddr;
	logic [APB_DW-1:0]     pwdata;
	logic [APB_DW-1:0]     prdata;
	logic                  pready;
	int                    fail_count;
	int                    pending;
	int                    burst_left = 0;
	int                    stall_left = 0;
	int                    stall_mode = 0;
	int                    req_count = 0;
	int                    node_span = 64;
	longint                cycle_count = 0;

	graph_color_refinement dut (.*);

	graph_color_refinement_checker checker_i (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(10, 200);
		end
		stall_left--;
		case (stall_mode)
			0, 1: m_axis_tready <= 1'b1;
			2: m_axis_tready <= 1'($urandom_range(0, 1));
			default: m_axis_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	function automatic logic [31:0] pack_request(logic [5:0] idx, logic [6:0] col,
			logic fx, logic [6:0] fr, logic [6:0] to, logic [2:0] wt);
		return {1'b0, wt, to, fr, fx, col, idx};
	endfunction

	task automatic send_request(op_t op, logic [31:0] data);
		bit ok;
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 16);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= data;
		do begin
			@(negedge clk);
			ok = s_axis_tready;
			@(posedge clk);
		end while (!ok);
		burst_left--;
		req_count++;
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_config(logic dir, logic usew, logic [2:0] wk, logic [6:0] nt);
		wait_idle();
		write_reg(REG_DIRECTED, 32'(dir));
		write_reg(REG_USE_WEIGHTS, 32'(usew));
		write_reg(REG_WEIGHT_KINDS, 32'(wk));
		write_reg(REG_NODE_TOTAL, 32'(nt));
		node_span = (nt < 1) ? 1 : (nt > 64) ? 64 : nt;
	endtask

	task automatic random_request();
		int pick;
		logic [6:0] col, fr, to;
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			col = ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'($urandom_range(1, 3));
			send_request(OP_LOAD_NODE, pack_request(6'($urandom), col,
				$urandom_range(0, 5) == 0, 7'($urandom), 7'($urandom), 3'($urandom)));
		end else if (pick < 85) begin
			if ($urandom_range(0, 9) == 0) begin
				fr = 7'($urandom);
				to = 7'($urandom);
			end else begin
				fr = 7'($urandom_range(1, node_span));
				to = 7'($urandom_range(1, node_span));
			end
			send_request(OP_LOAD_EDGE, pack_request(6'($urandom), 7'($urandom),
				1'($urandom_range(0, 1)), fr, to, 3'($urandom)));
		end else if (pick < 92) begin
			send_request(OP_CLEAR_EDGES, 32'($urandom) & 32'h7fff_ffff);
		end else begin
			send_request(OP_START, 32'($urandom) & 32'h7fff_ffff);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= OP_LOAD_NODE;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every node is loaded once so that no refinement reads an unwritten color.
		for (int i = 0; i < MAX_NODES; i++)
			send_request(OP_LOAD_NODE, pack_request(6'(i), 7'($urandom_range(1, 2)),
				$urandom_range(0, 7) == 0, 7'd0, 7'd0, 3'd0));

		send_request(OP_LOAD_NODE, pack_request(6'd0, 7'd0, 1'b0, 7'd0, 7'd0, 3'd0));
		send_request(OP_LOAD_NODE, pack_request(6'd63, 7'd127, 1'b1, 7'd0, 7'd0, 3'd0));
		send_request(OP_LOAD_NODE, pack_request(6'd1, 7'd64, 1'b1, 7'd0, 7'd0, 3'd0));
		send_request(OP_LOAD_EDGE, pack_request(6'd0, 7'd0, 1'b0, 7'd1, 7'd2, 3'd1));
		send_request(OP_LOAD_EDGE, pack_request(6'd0, 7'd0, 1'b0, 7'd64, 7'd64, 3'd4));
		send_request(OP_LOAD_EDGE, pack_request(6'd0, 7'd0, 1'b0, 7'd0, 7'd5, 3'd2));
		send_request(OP_LOAD_EDGE, pack_request(6'd0, 7'd0, 1'b0, 7'd65, 7'd3, 3'd2));
		send_request(OP_LOAD_EDGE, pack_request(6'd0, 7'd0, 1'b0, 7'd3, 7'd127, 3'd2));
		send_request(OP_LOAD_EDGE, pack_request(6'd0, 7'd0, 1'b0, 7'd2, 7'd3, 3'd0));
		send_request(OP_LOAD_EDGE, pack_request(6'd0, 7'd0, 1'b0, 7'd3, 7'd4, 3'd7));
		send_request(OP_START, '0);
		set_config(1'b1, 1'b1, 3'd4, 7'd64);
		send_request(OP_START, '0);
		set_config(1'b0, 1'b1, 3'd0, 7'd4);
		send_request(OP_START, '0);
		send_request(OP_CLEAR_EDGES, '0);
		send_request(OP_LOAD_EDGE, pack_request(6'd0, 7'd0, 1'b0, 7'd1, 7'd4, 3'd3));
		send_request(OP_START, '0);

		while (req_count < 240) begin
			case ($urandom_range(0, 5))
				0: set_config(1'b1, 1'b0, 3'd1, 7'd1);
				1: set_config(1'b0, 1'b1, 3'd7, 7'd127);
				2: set_config(1'b1, 1'b1, 3'd4, 7'd0);
				default: set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					3'($urandom), 7'($urandom_range(1, 12)));
			endcase
			repeat ($urandom_range(10, 30)) random_request();
			send_request(OP_START, '0);
		end

		send_request(OP_CLEAR_EDGES, '0);
		send_request(OP_START, '0);

		wait_idle();
		repeat (200) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
